// ----- hdl/dht_pkg.sv -----
// Package for the double-hashing table: sizes, status codes, FSM states.
// No dependencies; used by every other file.
package dht_pkg;
  localparam int TABLE_DEPTH = 1024;
  localparam int WORD_WIDTH  = 64;
  localparam int KEY_WIDTH   = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = 11;
  localparam int PRIME_W     = 10;
  localparam int TOT_W       = 32;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [0:0] REG_TABLE_SIZE = 1'd0;
  localparam logic [0:0] REG_STEP_PRIME = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_MOD1, S_MOD2, S_MOD3, S_READ, S_EVAL, S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } mod_req_t;
endpackage

// ----- hdl/dht_if.sv -----
// Valid/ready channel interfaces for the double-hashing table.
// Depends on dht_pkg.
interface dht_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [dht_pkg::KEY_WIDTH-1:0]   key;
  logic [dht_pkg::WORD_WIDTH-1:0]  entry_word;
  modport source (output valid, mode, key, entry_word, input ready);
  modport sink   (input valid, mode, key, entry_word, output ready);
endinterface

interface dht_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [9:0]                 slot;
  logic [9:0]                 probes;
  logic [dht_pkg::TOT_W-1:0]  insert_collisions;
  logic [dht_pkg::TOT_W-1:0]  search_collisions;
  modport source (output valid, status, slot, probes, insert_collisions,
                  search_collisions, input ready);
  modport sink   (input valid, status, slot, probes, insert_collisions,
                  search_collisions, output ready);
endinterface

interface dht_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/dht_mod.sv -----
// Restoring remainder unit, one quotient bit per cycle.
// Depends on dht_pkg.
module dht_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  dht_pkg::mod_req_t req,
  output logic              done,
  output logic [15:0]       rem
);
  import dht_pkg::*;
  logic [15:0] rem_r, rem_nxt, q_r, q_nxt, div_r, div_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, q_r[15]} - {1'b0, div_r};
    if (req.start) begin
      rem_nxt  = '0;
      q_nxt    = req.dividend;
      div_nxt  = req.divisor;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[16]) rem_nxt = trial[15:0];
      else rem_nxt = {rem_r[14:0], q_r[15]};
      q_nxt   = {q_r[14:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    div_r <= div_nxt;
  end

  assign done = busy_r && (cnt_r == 5'd1);
  assign rem  = trial[16] ? {rem_r[14:0], q_r[15]} : trial[15:0];
endmodule

// ----- hdl/dht_store.sv -----
// Slot storage: word memory plus used-bit memory, one read and one write port.
// The controller clears the used bits with a pass after reset. Depends on dht_pkg.
module dht_store (
  input  logic                           clk,
  input  logic [dht_pkg::IDX_W-1:0]      rd_addr,
  output logic [dht_pkg::WORD_WIDTH-1:0] rd_word,
  output logic                           rd_used,
  input  logic                           wr_en,
  input  logic [dht_pkg::IDX_W-1:0]      wr_addr,
  input  logic [dht_pkg::WORD_WIDTH-1:0] wr_word,
  input  logic                           wr_used
);
  import dht_pkg::*;
  logic [WORD_WIDTH-1:0] word_mem [TABLE_DEPTH];
  logic                  used_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_mem[wr_addr] <= wr_word;
      used_mem[wr_addr] <= wr_used;
    end
    rd_word <= word_mem[rd_addr];
    rd_used <= used_mem[rd_addr];
  end
endmodule

// ----- hdl/double_hash_table.sv -----
// Double-hashing hash table top level: control FSM, remainder unit and slot store.
// Sequence: key mod size, then key mod prime, then the step is reduced mod size only
// when it is not already below the size, then each slot is read and compared; the
// result is valid once the item ends, after the input transfer and N >= 1 slots read.
// One item at a time: a new input is taken only after the result has been accepted.
// Reset (rst_n, synchronous) zeroes both totals, then a pass over every slot clears the table.
module double_hash_table (
  input  logic         clk,
  input  logic         rst_n,
  dht_in_if.sink       in_ch,
  dht_out_if.source    out_ch,
  dht_cfg_if.sink      cfg_ch
);
  import dht_pkg::*;

  logic [SIZE_W-1:0]  size_cfg_r;
  logic [PRIME_W-1:0] prime_cfg_r;
  state_t state_r, state_nxt;

  logic                  mode_r;
  logic [KEY_WIDTH-1:0]  key_r;
  logic [WORD_WIDTH-1:0] word_r;
  logic [SIZE_W-1:0]     size_r;
  logic [PRIME_W-1:0]    prime_r;
  logic [IDX_W-1:0]      idx_r, idx_nxt, step_r, step_nxt;
  logic [IDX_W-1:0]      clr_r, clr_nxt;
  logic [SIZE_W-1:0]     iter_r, iter_nxt;
  logic [IDX_W-1:0]      miss_r, miss_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [IDX_W-1:0]      slot_r, slot_nxt;
  logic [TOT_W-1:0]      ins_tot_r, ins_tot_nxt, srch_tot_r, srch_tot_nxt;

  mod_req_t          mreq;
  logic              mdone;
  logic [15:0]       mrem;
  logic [PRIME_W-1:0] prime_eff;
  logic [SIZE_W-1:0] size_eff;
  logic [SIZE_W-1:0] step_raw;
  logic [SIZE_W:0]   adv;
  logic              in_xfer;
  logic              cfg_xfer;
  logic              ins_wr;
  logic              wr_en;
  logic              wr_used;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_WIDTH-1:0] rd_word;
  logic              rd_used;
  logic              end_item;
  logic              hit;

  // Configuration is taken only while idle, and ahead of an input offered in
  // the same cycle, so a register never changes under an item in flight.
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign cfg_xfer     = cfg_ch.valid && cfg_ch.ready;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r  <= SIZE_W'(TABLE_DEPTH);
      prime_cfg_r <= PRIME_W'(1021);
    end else if (cfg_xfer) begin
      if (cfg_ch.index == REG_TABLE_SIZE) size_cfg_r <= cfg_ch.data;
      else prime_cfg_r <= cfg_ch.data[PRIME_W-1:0];
    end
  end

  always_comb begin
    if (size_cfg_r == '0) size_eff = SIZE_W'(1);
    else if (size_cfg_r > SIZE_W'(TABLE_DEPTH)) size_eff = SIZE_W'(TABLE_DEPTH);
    else size_eff = size_cfg_r;
  end
  assign prime_eff = (prime_cfg_r == '0) ? PRIME_W'(1) : prime_cfg_r;

  // The remainder unit runs key mod size, then key mod prime, and finally
  // reduces the raw step mod size when the raw step is not already below it.
  always_comb begin
    mreq.start    = 1'b0;
    mreq.dividend = key_r;
    mreq.divisor  = 16'(size_r);
    if (in_xfer) begin
      mreq.start    = 1'b1;
      mreq.dividend = in_ch.key;
      mreq.divisor  = 16'(size_eff);
    end else if (state_r == S_MOD1 && mdone) begin
      mreq.start   = 1'b1;
      mreq.divisor = 16'(prime_r);
    end else if (state_r == S_MOD2 && mdone && step_raw >= size_r) begin
      mreq.start    = 1'b1;
      mreq.dividend = 16'(step_raw);
    end
  end

  dht_mod u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mdone), .rem(mrem));

  // prime - (key mod prime) lies in 1..1023.
  assign step_raw = SIZE_W'(prime_r) - SIZE_W'(mrem[PRIME_W-1:0]);
  // Both terms are below size, so one subtraction brings the sum back in range.
  assign adv      = (SIZE_W+1)'(idx_r) + (SIZE_W+1)'(step_r);

  // The write port serves the clearing pass after reset and the insert write.
  assign rd_addr = idx_r;
  assign ins_wr  = (state_r == S_EVAL) && !mode_r && !rd_used;
  assign wr_en   = (state_r == S_CLEAR) || ins_wr;
  assign wr_addr = (state_r == S_CLEAR) ? clr_r : idx_r;
  assign wr_used = (state_r != S_CLEAR);

  dht_store u_store (
    .clk(clk), .rd_addr(rd_addr), .rd_word(rd_word), .rd_used(rd_used),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_word(word_r), .wr_used(wr_used)
  );

  assign hit = rd_used && (rd_word == word_r);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    step_nxt   = step_r;
    clr_nxt    = clr_r;
    iter_nxt   = iter_r;
    miss_nxt   = miss_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    end_item   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(TABLE_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_xfer) state_nxt = S_MOD1;
      S_MOD1: if (mdone) begin
        idx_nxt   = mrem[IDX_W-1:0];
        iter_nxt  = '0;
        state_nxt = S_MOD2;
      end
      S_MOD2: if (mdone) begin
        // A raw step already below the size needs no further reduction.
        if (step_raw < size_r) begin
          step_nxt  = step_raw[IDX_W-1:0];
          state_nxt = S_READ;
        end else begin
          state_nxt = S_MOD3;
        end
      end
      S_MOD3: if (mdone) begin
        step_nxt  = mrem[IDX_W-1:0];
        state_nxt = S_READ;
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_READ;
        if (!mode_r) begin
          if (!rd_used) begin
            status_nxt = ST_INSERTED; slot_nxt = idx_r; end_item = 1'b1;
          end
        end else begin
          if (hit) begin
            status_nxt = ST_FOUND; slot_nxt = idx_r; end_item = 1'b1;
          end else if (iter_r != '0) begin
            miss_nxt = miss_r + IDX_W'(1);
            if (!rd_used) begin
              status_nxt = ST_NOT_FOUND; slot_nxt = '0; end_item = 1'b1;
            end
          end else if (!rd_used) begin
            status_nxt = ST_NOT_FOUND; slot_nxt = '0; end_item = 1'b1;
          end
        end
        if (!end_item) begin
          if (!mode_r && iter_r != '0) miss_nxt = miss_r + IDX_W'(1);
          if ((iter_r + SIZE_W'(1)) >= size_r) begin
            status_nxt = mode_r ? ST_NOT_FOUND : ST_FULL;
            slot_nxt   = '0;
            end_item   = 1'b1;
          end else begin
            iter_nxt = iter_r + SIZE_W'(1);
            idx_nxt  = (adv >= (SIZE_W+1)'(size_r)) ?
                       IDX_W'(adv - (SIZE_W+1)'(size_r)) : IDX_W'(adv);
          end
        end
        if (end_item) state_nxt = S_DONE;
      end
      S_DONE: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  function automatic logic [TOT_W-1:0] sat_add(logic [TOT_W-1:0] a, logic [IDX_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + (TOT_W+1)'(b);
    return s[TOT_W] ? '1 : s[TOT_W-1:0];
  endfunction

  always_comb begin
    ins_tot_nxt  = ins_tot_r;
    srch_tot_nxt = srch_tot_r;
    if (state_r == S_EVAL && state_nxt == S_DONE) begin
      if (mode_r) srch_tot_nxt = sat_add(srch_tot_r, miss_nxt);
      else ins_tot_nxt = sat_add(ins_tot_r, miss_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      ins_tot_r  <= '0;
      srch_tot_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      ins_tot_r  <= ins_tot_nxt;
      srch_tot_r <= srch_tot_nxt;
    end
    if (in_xfer) begin
      mode_r  <= in_ch.mode;
      key_r   <= in_ch.key;
      word_r  <= in_ch.entry_word;
      size_r  <= size_eff;
      prime_r <= prime_eff;
      miss_r  <= '0;
    end else begin
      miss_r <= miss_nxt;
    end
    idx_r    <= idx_nxt;
    step_r   <= step_nxt;
    iter_r   <= iter_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
  end

  assign in_ch.ready                = (state_r == S_IDLE) && !cfg_ch.valid;
  assign out_ch.valid               = (state_r == S_DONE);
  assign out_ch.status              = status_r;
  assign out_ch.slot                = slot_r;
  assign out_ch.probes              = miss_r;
  assign out_ch.insert_collisions   = ins_tot_r;
  assign out_ch.search_collisions   = srch_tot_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
  a_write: assert property (@(posedge clk) disable iff (!rst_n)
    ins_wr |=> (out_ch.valid && out_ch.status == ST_INSERTED))
    else $error("write without insert result");
endmodule
